// File: hw/rtl/scca_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scca_pkg
// Shared constants, types and helpers for the size-class chunk allocator.
// ----------------------------------------------------------------------------
package scca_pkg;

  // Pool geometry (PAGE_BYTES is a power of two)
  localparam int PAGE_BYTES   = 4096;
  localparam int POOL_PAGES   = 16;
  localparam int SIZE_CLASSES = 7;

  localparam int ADDR_W       = 16;
  localparam int ADDR_SPACE   = 65536;
  localparam int HDR_BYTES    = 16;
  localparam int LINK_DEPTH   = 4096;
  localparam int LINK_AW      = 12;
  localparam int LINK_W       = 17;
  localparam int SPACE_PAGES  = ADDR_SPACE / PAGE_BYTES;
  localparam int USABLE_PAGES = (POOL_PAGES < SPACE_PAGES) ? POOL_PAGES : SPACE_PAGES;
  localparam int PAGE_SHIFT   = $clog2(PAGE_BYTES);
  localparam int PG_CNT_W     = $clog2(USABLE_PAGES + 1);
  localparam int PIDX_W       = (USABLE_PAGES > 1) ? $clog2(USABLE_PAGES) : 1;
  localparam int OFF_W        = $clog2(PAGE_BYTES) + 1;
  localparam int CLS_W        = 3;
  localparam int SIZE_W       = 32;

  // Stream widths
  localparam int S_TDATA_W    = 48;
  localparam int M_TDATA_W    = 24;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_TOO_LARGE = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_BAD_FREE  = 2'd3;

  // Request kinds
  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  typedef logic [CLS_W-1:0]  cls_t;
  typedef logic [LINK_W-1:0] link_t;   // [16] list not empty, [15:0] address

  function automatic logic [ADDR_W-1:0] class_bytes(input cls_t c);
    logic [ADDR_W-1:0] b;
    case (c)
      3'd0:    b = 16'h0010;
      3'd1:    b = 16'h0030;
      3'd2:    b = 16'h0050;
      3'd3:    b = 16'h00f0;
      3'd4:    b = 16'h0110;
      3'd5:    b = 16'h0330;
      3'd6:    b = 16'h0550;
      default: b = 16'h0010;
    endcase
    return b;
  endfunction

endpackage

// File: hw/rtl/scca_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scca_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module scca_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: hw/rtl/size_class_chunk_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// size_class_chunk_allocator_unit
// Segregated LIFO free-list allocator: seven chunk classes over a page pool.
// ----------------------------------------------------------------------------
//  channel  dir  tdata (low bit up)              tuser
//  s_*      in   nbytes[31:0], free_addr[47:32]  req_type (0 alloc, 1 free)
//  m_*      out  chunk_addr[15:0], status[17:16] -
//
//  Alloc from a non-empty list: accept, link read, link return, result.
//  Free: accept, head push or reject, result. Alloc that opens a new page
//  carves one chunk per cycle from the top down, then pops the lowest; the carve walk
//  shares one subtractor and the single link RAM port.
//  Reset clears the list heads and the page count; the link RAM is not cleared.
//  s_tready is high only when idle; a waiting result stalls the block.
// ----------------------------------------------------------------------------
module size_class_chunk_allocator_unit (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [scca_pkg::S_TDATA_W-1:0]  s_tdata,   // nbytes, free_addr
  input  logic                            s_tuser,   // req_type
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [scca_pkg::M_TDATA_W-1:0]  m_tdata    // chunk_addr, status
);
  import scca_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DECODE   = 3'd1;
  localparam logic [2:0] S_FILL     = 3'd2;
  localparam logic [2:0] S_POP      = 3'd3;
  localparam logic [2:0] S_POP_WAIT = 3'd4;
  localparam logic [2:0] S_DONE     = 3'd5;

  logic [2:0]          state;
  link_t               head [SIZE_CLASSES];
  cls_t                page_cls [USABLE_PAGES];
  logic [PG_CNT_W-1:0] pages;

  logic                req_kind;
  cls_t                cls;
  logic                too_big;
  logic [ADDR_W-1:0]   faddr;
  logic [OFF_W-1:0]    off;
  logic [ADDR_W-1:0]   base;
  logic [ADDR_W-1:0]   res_addr;
  logic [1:0]          res_status;

  // request decode at accept
  logic [SIZE_W-1:0]   in_size;
  cls_t                in_cls;
  logic                in_big;

  assign in_size = s_tdata[SIZE_W-1:0];

  always_comb begin
    in_cls = cls_t'(SIZE_CLASSES - 1);
    for (int c = SIZE_CLASSES - 1; c >= 0; c--) begin
      if (in_size <= {16'd0, class_bytes(cls_t'(c))}) begin
        in_cls = cls_t'(c);
      end
    end
    in_big = in_size > {16'd0, class_bytes(cls_t'(SIZE_CLASSES - 1))};
  end

  // free path: page lookup
  logic [ADDR_W-1:0] free_page;
  logic              free_unused;
  cls_t              free_cls_raw;
  cls_t              free_cls;

  assign free_page    = faddr >> PAGE_SHIFT;
  assign free_unused  = {1'b0, free_page} >= (ADDR_W + 1)'(pages);
  assign free_cls_raw = page_cls[free_page[PIDX_W-1:0]];
  assign free_cls     = (free_cls_raw == cls_t'(SIZE_CLASSES)) ? '0 : free_cls_raw;

  // carve unit: one subtractor walks the page from the top down
  logic [OFF_W:0]    diff;
  logic              borrow;
  logic [ADDR_W-1:0] push_addr;

  assign diff      = {1'b0, off} - (OFF_W + 1)'(class_bytes(cls));
  assign borrow    = diff[OFF_W];
  assign push_addr = base + ADDR_W'(HDR_BYTES) + ADDR_W'(diff[OFF_W-1:0]);

  // link RAM
  logic              ram_we;
  logic [LINK_AW-1:0] ram_addr;
  link_t             ram_wdata;
  link_t             ram_rdata;

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = head[cls][ADDR_W-1:4];
    ram_wdata = head[cls];
    case (state)
      S_DECODE: begin
        if (req_kind == REQ_FREE) begin
          ram_we    = !free_unused;
          ram_addr  = faddr[ADDR_W-1:4];
          ram_wdata = head[free_cls];
        end
      end
      S_FILL: begin
        ram_we   = !borrow;
        ram_addr = push_addr[ADDR_W-1:4];
      end
      default: begin
      end
    endcase
  end

  scca_ram #(
    .WIDTH(LINK_W),
    .DEPTH(LINK_DEPTH)
  ) u_link_ram (
    .clk  (clk),
    .we   (ram_we),
    .addr (ram_addr),
    .wdata(ram_wdata),
    .rdata(ram_rdata)
  );

  assign s_tready = (state == S_IDLE) && !rst;

  // page class table, written when a page is handed out
  always_ff @(posedge clk) begin
    if (state == S_DECODE && req_kind == REQ_ALLOC && !too_big && !head[cls][ADDR_W]
        && pages < PG_CNT_W'(USABLE_PAGES)) begin
      page_cls[pages[PIDX_W-1:0]] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      pages    <= '0;
      m_tvalid <= 1'b0;
      for (int c = 0; c < SIZE_CLASSES; c++) begin
        head[c] <= '0;
      end
    end else begin
      if (m_tvalid && m_tready && state != S_DONE) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (s_tvalid) begin
            req_kind <= s_tuser;
            cls      <= in_cls;
            too_big  <= in_big;
            faddr    <= s_tdata[SIZE_W +: ADDR_W];
            state    <= S_DECODE;
          end
        end
        S_DECODE: begin
          res_addr <= '0;
          if (req_kind == REQ_FREE) begin
            if (free_unused) begin
              res_status <= ST_BAD_FREE;
            end else begin
              res_status     <= ST_OK;
              head[free_cls] <= {1'b1, faddr};
            end
            state <= S_DONE;
          end else if (too_big) begin
            res_status <= ST_TOO_LARGE;
            state      <= S_DONE;
          end else if (head[cls][ADDR_W]) begin
            res_status <= ST_OK;
            state      <= S_POP_WAIT;    // link read issued this cycle
          end else if (pages >= PG_CNT_W'(USABLE_PAGES)) begin
            res_status <= ST_EXHAUSTED;
            state      <= S_DONE;
          end else begin
            res_status <= ST_OK;
            base       <= ADDR_W'(pages) << PAGE_SHIFT;
            off        <= OFF_W'(PAGE_BYTES - HDR_BYTES);
            pages      <= pages + 1'b1;
            state      <= S_FILL;
          end
        end
        S_FILL: begin
          if (borrow) begin
            state <= S_POP;
          end else begin
            head[cls] <= {1'b1, push_addr};
            off       <= diff[OFF_W-1:0];
          end
        end
        S_POP: begin
          state <= S_POP_WAIT;
        end
        S_POP_WAIT: begin
          res_addr  <= head[cls][ADDR_W-1:0];
          head[cls] <= ram_rdata;
          state     <= S_DONE;
        end
        S_DONE: begin
          // hold until the output register is free
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'd0, res_status, res_addr};
            state    <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  ap_pages_bound: assert property (@(posedge clk) disable iff (rst)
    pages <= PG_CNT_W'(USABLE_PAGES))
    else $error("page count beyond pool");

  ap_err_no_addr: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[17:16] != ST_OK |-> m_tdata[15:0] == '0)
    else $error("error beat carries an address");

  ap_fill_nonempty: assert property (@(posedge clk) disable iff (rst)
    state == S_POP |-> head[cls][ADDR_W])
    else $error("list empty after page carve");

  ap_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> state == S_DECODE)
    else $error("accepted beat not decoded");

endmodule

// File: tb/tb_size_class_chunk_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_size_class_chunk_allocator_unit
// Drives alloc and free beats into the chunk allocator in bursts and stalls
// the result side on a rotating pattern. A local model of the free lists,
// page classes and page count predicts the address and status of each
// accepted beat, and every returned beat is checked in order.
// ----------------------------------------------------------------------------
module tb_size_class_chunk_allocator_unit;
  import scca_pkg::*;

  localparam int  RANDOM_REQS  = 850;
  localparam int  TAIL_CYCLES  = 300;
  localparam time RUN_LIMIT_NS = 10_000_000;

  typedef struct {
    logic              kind;
    logic [SIZE_W-1:0] size;
    logic [ADDR_W-1:0] addr;
  } alloc_req_t;

  typedef struct {
    logic [ADDR_W-1:0] addr;
    logic [1:0]        status;
  } alloc_rsp_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [S_TDATA_W-1:0] s_tdata = '0;
  logic                 s_tuser = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  logic [M_TDATA_W-1:0] m_tdata;

  size_class_chunk_allocator_unit dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),    // nbytes, free_addr
    .s_tuser  (s_tuser),    // req_type
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)     // chunk_addr, status
  );

  // Allocator model state
  link_t       list_head [SIZE_CLASSES];
  link_t       next_link [LINK_DEPTH];
  cls_t        page_class [USABLE_PAGES];
  int          pages_used;

  alloc_req_t  req_queue [$];
  alloc_rsp_t  pending_results [$];
  logic [ADDR_W-1:0] live_chunks [$];
  alloc_req_t  cur_req;
  logic        beat_taken = 1'b0;
  int          reqs_queued = 0;
  int          results_seen = 0;
  int          random_queued = 0;
  int          errors = 0;

  initial begin
    forever #4 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("tb_size_class_chunk_allocator_unit: done, errors");
    $finish;
  end

  function automatic logic [ADDR_W-1:0] chunk_bytes_of(input int c);
    case (c)
      0:       return 16'h0010;
      1:       return 16'h0030;
      2:       return 16'h0050;
      3:       return 16'h00f0;
      4:       return 16'h0110;
      5:       return 16'h0330;
      default: return 16'h0550;
    endcase
  endfunction

  function automatic int class_for_size(input logic [SIZE_W-1:0] size);
    for (int c = 0; c < SIZE_CLASSES; c++)
      if (size <= {16'h0, chunk_bytes_of(c)}) return c;
    return -1;
  endfunction

  function automatic void model_reset();
    for (int c = 0; c < SIZE_CLASSES; c++) list_head[c] = '0;
    for (int i = 0; i < LINK_DEPTH; i++) next_link[i] = '0;
    for (int p = 0; p < USABLE_PAGES; p++) page_class[p] = '0;
    pages_used = 0;
  endfunction

  function automatic void push_chunk(input int c, input logic [ADDR_W-1:0] a);
    next_link[a >> 4] = list_head[c];
    list_head[c] = {1'b1, a};
  endfunction

  // Carve a fresh page top-down so the lowest chunk ends up at the head
  function automatic void carve_page(input int c);
    int base;
    int sz;
    base = pages_used * PAGE_BYTES;
    sz = int'(chunk_bytes_of(c));
    page_class[pages_used] = cls_t'(c);
    pages_used++;
    for (int off = PAGE_BYTES - HDR_BYTES; off >= sz; off -= sz)
      push_chunk(c, 16'(base + HDR_BYTES + off - sz));
  endfunction

  function automatic alloc_rsp_t predict_response(input alloc_req_t rq);
    alloc_rsp_t rsp;
    int c;
    int page;
    rsp.addr = '0;
    rsp.status = ST_OK;
    if (rq.kind == REQ_ALLOC) begin
      c = class_for_size(rq.size);
      if (c < 0) begin
        rsp.status = ST_TOO_LARGE;
      end else if (!list_head[c][16] && pages_used >= USABLE_PAGES) begin
        rsp.status = ST_EXHAUSTED;
      end else begin
        if (!list_head[c][16]) carve_page(c);
        rsp.addr = list_head[c][15:0];
        list_head[c] = next_link[rsp.addr >> 4];
        live_chunks.push_back(rsp.addr);
      end
    end else begin
      page = int'(rq.addr) / PAGE_BYTES;
      if (page >= pages_used) rsp.status = ST_BAD_FREE;
      else push_chunk(int'(page_class[page]) % SIZE_CLASSES, rq.addr);
    end
    return rsp;
  endfunction

  function automatic void queue_req(input logic kind, input logic [SIZE_W-1:0] size,
                                    input logic [ADDR_W-1:0] addr);
    alloc_req_t rq;
    rq.kind = kind;
    rq.size = size;
    rq.addr = addr;
    req_queue.push_back(rq);
    reqs_queued++;
  endfunction

  // Mostly sizes inside a class, leaning to the small ones, plus edges and oversize
  function automatic logic [SIZE_W-1:0] pick_alloc_size();
    int r;
    int c;
    int w;
    logic [SIZE_W-1:0] lo;
    logic [SIZE_W-1:0] hi;
    r = $urandom_range(0, 99);
    if (r < 65) begin
      w = $urandom_range(0, 9);
      c = (w < 3) ? 0 : (w < 5) ? 1 : (w < 7) ? 2 : (w == 7) ? 3 : (w == 8) ? 4 :
          $urandom_range(5, 6);
      lo = (c == 0) ? 32'h0 : {16'h0, chunk_bytes_of(c - 1)} + 32'h1;
      hi = {16'h0, chunk_bytes_of(c)};
      return $urandom_range(hi, lo);
    end else if (r < 80) begin
      c = $urandom_range(0, SIZE_CLASSES - 1);
      return {16'h0, chunk_bytes_of(c)} + 32'($urandom_range(0, 1));
    end else if (r < 92) begin
      return $urandom;
    end
    return $urandom_range(32'h0000ffff, 32'h00000551);
  endfunction

  // Mostly live chunks; the rest are headers, odd offsets and unused pages
  function automatic logic [ADDR_W-1:0] pick_free_addr();
    int r;
    int idx;
    int page;
    logic [ADDR_W-1:0] a;
    r = $urandom_range(0, 99);
    if (live_chunks.size() > 0 && r < 80) begin
      idx = $urandom_range(0, live_chunks.size() - 1);
      a = live_chunks[idx];
      live_chunks.delete(idx);
      return a;
    end else if (pages_used > 0 && r < 92) begin
      page = $urandom_range(0, pages_used - 1);
      if ($urandom_range(0, 3) == 0) return 16'(page * PAGE_BYTES);
      return 16'(page * PAGE_BYTES + $urandom_range(0, PAGE_BYTES - 1));
    end
    return 16'($urandom_range(0, 65535));
  endfunction

  function automatic void queue_random_req();
    if ($urandom_range(0, 99) < 55) queue_req(REQ_ALLOC, pick_alloc_size(), 16'($urandom));
    else queue_req(REQ_FREE, $urandom, pick_free_addr());
    random_queued++;
  endfunction

  // Hold off until every queued beat has come back
  task automatic wait_all_done();
    do begin
      @(posedge clk);
      #1;
    end while (results_seen != reqs_queued);
  endtask

  // Accept side: predict on each request handshake
  always @(posedge clk) begin
    beat_taken = 1'b0;
    if (rst) begin
      model_reset();
    end else if (s_tvalid && s_tready) begin
      beat_taken = 1'b1;
      pending_results.push_back(predict_response(cur_req));
    end
  end

  // Result monitor
  always @(posedge clk) begin
    alloc_rsp_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: result beat with nothing outstanding: addr %h status %0d",
                 $time, m_tdata[15:0], m_tdata[17:16]);
        errors++;
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (m_tdata[15:0] !== want.addr) begin
          $display("%0t: chunk_addr expected %h actual %h", $time, want.addr, m_tdata[15:0]);
          errors++;
        end
        if (m_tdata[17:16] !== want.status) begin
          $display("%0t: status expected %0d actual %0d", $time, want.status,
                   m_tdata[17:16]);
          errors++;
        end
      end
    end
  end

  // Request driver: bursts of beats with random gaps between them
  int gap_left = 0;
  int burst_left = 1;

  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (beat_taken || !s_tvalid) begin
      if (gap_left > 0 || req_queue.size() == 0) begin
        s_tvalid <= 1'b0;
        if (gap_left > 0) gap_left--;
      end else begin
        cur_req = req_queue[0];
        req_queue.delete(0);
        s_tvalid <= 1'b1;
        s_tdata <= {cur_req.addr, cur_req.size};
        s_tuser <= cur_req.kind;
        burst_left--;
        if (burst_left <= 0) begin
          burst_left = $urandom_range(1, 24);
          gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
      end
    end
  end

  // Result side: rotate a ready mask and reload it when mask_age runs out
  logic [7:0] ready_mask = 8'hff;
  int         mask_age = 0;

  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (mask_age == 0) begin
        mask_age = 32;
        ready_mask = ($urandom_range(0, 3) == 0) ? 8'hff : (8'($urandom) | 8'h01);
      end
      mask_age--;
      m_tready <= ready_mask[0];
      ready_mask = {ready_mask[0], ready_mask[7:1]};
    end
  end

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    @(posedge clk);
    #1;

    // Free before any page is out, then open every class with edge sizes
    queue_req(REQ_FREE, 32'h0, 16'h0000);
    queue_req(REQ_ALLOC, 32'h0, 16'h0000);
    queue_req(REQ_ALLOC, 32'h10, 16'hffff);
    queue_req(REQ_ALLOC, 32'h11, 16'h0);
    queue_req(REQ_ALLOC, 32'h30, 16'h0);
    queue_req(REQ_ALLOC, 32'h31, 16'h0);
    queue_req(REQ_ALLOC, 32'h50, 16'h0);
    queue_req(REQ_ALLOC, 32'h51, 16'h0);
    queue_req(REQ_ALLOC, 32'hf0, 16'h0);
    queue_req(REQ_ALLOC, 32'hf1, 16'h0);
    queue_req(REQ_ALLOC, 32'h110, 16'h0);
    queue_req(REQ_ALLOC, 32'h111, 16'h0);
    queue_req(REQ_ALLOC, 32'h330, 16'h0);
    queue_req(REQ_ALLOC, 32'h331, 16'h0);
    queue_req(REQ_ALLOC, 32'h550, 16'h0);
    // Oversize and free into unused pages
    queue_req(REQ_ALLOC, 32'h551, 16'h0);
    queue_req(REQ_ALLOC, 32'hffffffff, 16'hffff);
    queue_req(REQ_FREE, 32'hffffffff, 16'hffff);
    // Normal free and reuse, header free, page-0 header yields address zero
    queue_req(REQ_FREE, 32'h0, 16'h0010);
    queue_req(REQ_ALLOC, 32'h1, 16'h0);
    queue_req(REQ_FREE, 32'h0, 16'h1000);
    queue_req(REQ_ALLOC, 32'h30, 16'h0);
    queue_req(REQ_FREE, 32'h0, 16'h0000);
    queue_req(REQ_ALLOC, 32'h5, 16'h0);
    // Unaligned free comes back as given
    queue_req(REQ_FREE, 32'h0, 16'h2013);
    queue_req(REQ_ALLOC, 32'h40, 16'h0);
    wait_all_done();

    while (random_queued < RANDOM_REQS) begin
      repeat ($urandom_range(20, 60)) queue_random_req();
      wait_all_done();
    end

    repeat (TAIL_CYCLES) @(negedge clk);
    if (pending_results.size() != 0) begin
      $display("%0t: %0d result beats never arrived", $time, pending_results.size());
      errors++;
    end
    if (errors == 0) begin
      $display("tb_size_class_chunk_allocator_unit: done, clean");
    end else begin
      $display("tb_size_class_chunk_allocator_unit: done, errors");
    end
    $finish;
  end

endmodule
